[hw/rtl/wto_pkg.sv]
// ----------------------------------------------------------------------------
// wto_pkg
// Shared types, constants and lookup tables of the wavetable oscillator.
// ----------------------------------------------------------------------------
package wto_pkg;

    // Default sizes of the oscillator storage
    localparam int DEF_MAX_FRAMES   = 4;
    localparam int DEF_MAX_BANDS    = 16;
    localparam int DEF_TABLE_LENGTH = 2048;

    // Increment ceiling, floor(0.499 * 2^32)
    localparam logic [31:0] INC_LIMIT  = 32'd2143188680;
    // Asym midpoint span, floor(0.38 * 2^32)
    localparam logic [30:0] ASYM_SPAN  = 31'd1632087572;
    // Band test: 20*h*ratio <= 9*2^32 is h*ratio <= floor(9*2^32/20)
    localparam logic [47:0] BAND_LIMIT = 48'd1932735283;
    // 1.0 on the 0.32 phase scale
    localparam logic [32:0] ONE_PHASE  = 33'h1_0000_0000;

    typedef enum logic [1:0] {
        CMD_GENERATE = 2'd0,
        CMD_LOAD_SMP = 2'd1,
        CMD_LOAD_LIM = 2'd2,
        CMD_SET_PHS  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        PROC_OFF    = 3'd0,
        PROC_BEND_P = 3'd1,
        PROC_BEND_M = 3'd2,
        PROC_BEND_B = 3'd3,
        PROC_SYNC   = 3'd4,
        PROC_MIRROR = 3'd5,
        PROC_ASYM   = 3'd6
    } t_proc;

    typedef logic [23:0] t_log_rom [256];
    typedef logic [30:0] t_exp_rom [256];

    // Integer square root, bit by bit
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bits;
        v    = v_in;
        res  = '0;
        bits = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (v >= res + bits) begin
                v   = v - (res + bits);
                res = (res >> 1) + bits;
            end else begin
                res = res >> 1;
            end
            bits = bits >> 2;
        end
        return res;
    endfunction

    // log2 of 1 + i/256, Q0.24, by repeated squaring
    function automatic t_log_rom build_log_rom();
        t_log_rom    rom;
        logic [63:0] m;
        logic [23:0] y;
        for (int i = 0; i < 256; i++) begin
            m = 64'(256 + i) << 22;
            y = '0;
            for (int b = 23; b >= 0; b--) begin
                m = (m * m) >> 30;
                if (m >= (64'd2 << 30)) begin
                    m    = m >> 1;
                    y[b] = 1'b1;
                end
            end
            rom[i] = y;
        end
        return rom;
    endfunction

    // 2^(i/256), Q1.30, from products of repeated square roots of two
    function automatic t_exp_rom build_exp_rom();
        t_exp_rom    rom;
        logic [63:0] roots [1:8];
        logic [63:0] r;
        logic [63:0] v;
        r = 64'd2 << 30;
        for (int k = 1; k <= 8; k++) begin
            r        = isqrt64(r << 30);
            roots[k] = r;
        end
        for (int i = 0; i < 256; i++) begin
            v = 64'd1 << 30;
            for (int k = 1; k <= 8; k++) begin
                if (((i >> (8 - k)) & 1) == 1) begin
                    v = (v * roots[k]) >> 30;
                end
            end
            rom[i] = v[30:0];
        end
        return rom;
    endfunction

    localparam t_log_rom LOG_ROM = build_log_rom();
    localparam t_exp_rom EXP_ROM = build_exp_rom();

endpackage

[hw/rtl/wto_ram.sv]
// ----------------------------------------------------------------------------
// wto_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module wto_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write or read one word per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/wavetable_oscillator_unit.sv]
// ----------------------------------------------------------------------------
// wavetable_oscillator_unit
// Band-limited wavetable oscillator with two phase-shaping stages.
// ----------------------------------------------------------------------------
// Usage:
//  Input beats carry a command: generate a sample, load a table sample, load
//  a band harmonic limit, or set the phase. Each input beat gives one output
//  beat; only a generate beat sets o_sample_valid and a non-zero sample.
//  o_in_stall is high while a beat is in work; one beat is worked at a time.
//  Load and set beats go from decode straight to the output. A generate beat
//  runs a band search of up to one step per band, then per shaping stage
//  the power unit (normalizing one bit per leading zero of the phase), the
//  asym divider (32 steps) or a single blend or scale, then four reads of
//  the single-port sample RAM and six passes through the shared multiplier.
//  Every step shares one 33x25 multiplier under a one-hot sequencer.
//  The result sits in an output register, so a new beat is taken while the
//  last result waits; if the receiver stalls, the next result waits in the
//  sequencer until the register frees.
//  Reset clears the phase to zero and sets both config registers to one.
//  Table and harmonic limit storage hold nothing until loaded.
//  Config registers (APB, byte address 4*i): frames_in_use, bands_in_use.
// ----------------------------------------------------------------------------
module wavetable_oscillator_unit #(
    parameter int MAX_FRAMES   = wto_pkg::DEF_MAX_FRAMES,
    parameter int MAX_BANDS    = wto_pkg::DEF_MAX_BANDS,
    parameter int TABLE_LENGTH = wto_pkg::DEF_TABLE_LENGTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // Input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_command,
    input  logic [31:0]        i_frequency_ratio,
    input  logic [16:0]        i_position,
    input  logic [2:0]         i_process_a,
    input  logic [16:0]        i_amount_a,
    input  logic [2:0]         i_process_b,
    input  logic [16:0]        i_amount_b,
    input  logic [1:0]         i_frame_select,
    input  logic [3:0]         i_band_select,
    input  logic [10:0]        i_sample_index,
    input  logic signed [23:0] i_load_value,
    input  logic [31:0]        i_start_phase,
    // Output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [23:0] o_sample_out,
    output logic               o_sample_valid
);

    import wto_pkg::*;

    localparam int MEM_DEPTH = MAX_FRAMES * MAX_BANDS * TABLE_LENGTH;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int IW        = $clog2(TABLE_LENGTH);
    localparam int BW        = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;

    typedef enum logic [30:0] {
        S_IDLE   = 31'b1 << 0,
        S_DECODE = 31'b1 << 1,
        S_BAND   = 31'b1 << 2,
        S_STG    = 31'b1 << 3,
        S_PNORM  = 31'b1 << 4,
        S_PLOGA  = 31'b1 << 5,
        S_PLOGB  = 31'b1 << 6,
        S_PEXP   = 31'b1 << 7,
        S_PEXPA  = 31'b1 << 8,
        S_PEXPB  = 31'b1 << 9,
        S_PSHIFT = 31'b1 << 10,
        S_POST   = 31'b1 << 11,
        S_BLEND1 = 31'b1 << 12,
        S_BLEND2 = 31'b1 << 13,
        S_SYNC   = 31'b1 << 14,
        S_AMID   = 31'b1 << 15,
        S_ASET   = 31'b1 << 16,
        S_DIV    = 31'b1 << 17,
        S_TAB    = 31'b1 << 18,
        S_RD0    = 31'b1 << 19,
        S_RD1    = 31'b1 << 20,
        S_RD2    = 31'b1 << 21,
        S_RD3    = 31'b1 << 22,
        S_RD4    = 31'b1 << 23,
        S_MIX0   = 31'b1 << 24,
        S_MIX1   = 31'b1 << 25,
        S_MIX2   = 31'b1 << 26,
        S_MIX3   = 31'b1 << 27,
        S_MIX4   = 31'b1 << 28,
        S_MIX5   = 31'b1 << 29,
        S_DONE   = 31'b1 << 30
    } t_state;

    // Control registers
    t_state r_state, n_state;
    logic [2:0]  r_frames;
    logic [4:0]  r_bands;
    logic [31:0] r_phase, n_phase;
    logic        r_out_valid, n_out_valid;
    logic [23:0] r_out_sample, n_out_sample;
    logic        r_out_gen, n_out_gen;

    // Captured input beat
    logic [1:0]  r_cmd;
    logic [31:0] r_ratio;
    logic [16:0] r_pos;
    logic [2:0]  r_proc_a, r_proc_b;
    logic [16:0] r_amt_a, r_amt_b;
    logic [1:0]  r_fsel;
    logic [3:0]  r_bsel;
    logic [10:0] r_sidx;
    logic [23:0] r_lval;
    logic [31:0] r_sphase;

    // Harmonic limits, one per band
    logic [15:0] r_lim [MAX_BANDS];
    logic        lim_we;
    logic [15:0] lim_wdata;

    // Working registers
    logic [2:0]    r_nbd_unused_guard;
    logic [4:0]    r_nbd, n_nbd;
    logic [2:0]    r_fa, n_fa, r_fb, n_fb;
    logic [15:0]   r_ff, n_ff;
    logic [BW-1:0] r_band, n_band;
    logic [1:0]    r_stg, n_stg;
    logic [31:0]   r_p, n_p;
    logic [2:0]    r_kind, n_kind;
    logic [16:0]   r_a, n_a;
    logic [18:0]   r_e, n_e;
    logic [32:0]   r_px, n_px;
    logic [4:0]    r_lz, n_lz;
    logic [30:0]   r_lo, n_lo;
    logic [24:0]   r_dif, n_dif;
    logic [22:0]   r_frac, n_frac;
    logic [29:0]   r_neg, n_neg;
    logic [32:0]   r_prod, n_prod;
    logic [31:0]   r_val, n_val;
    logic [9:0]    r_s, n_s;
    logic [32:0]   r_pow, n_pow;
    logic [32:0]   r_sh, n_sh;
    logic [49:0]   r_acc, n_acc;
    logic [31:0]   r_mid, n_mid;
    logic [31:0]   r_den, n_den;
    logic [31:0]   r_rem, n_rem;
    logic [31:0]   r_ql, n_ql;
    logic          r_hi, n_hi;
    logic [4:0]    r_cnt, n_cnt;
    logic [IW-1:0] r_idx, n_idx, r_nidx, n_nidx;
    logic [15:0]   r_tf, n_tf;
    logic [AW-1:0] r_base_a, n_base_a, r_base_b, n_base_b;
    logic [23:0]   r_s0, n_s0, r_s1, n_s1, r_s2, n_s2, r_s3, n_s3;
    logic [23:0]   r_va, n_va, r_vb, n_vb, r_res, n_res;

    // Shared multiplier and RAM port
    logic [32:0]   mul_a;
    logic [24:0]   mul_b;
    logic [57:0]   mul_p;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [23:0]   ram_wdata;
    logic [23:0]   ram_rdata;

    logic in_acc;
    logic cfg_wr;

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign cfg_wr     = psel && penable && pwrite;
    assign pready     = 1'b1;
    assign prdata     = paddr[2] ? {27'd0, r_bands} : {29'd0, r_frames};

    assign o_out_valid    = r_out_valid;
    assign o_sample_out   = r_out_sample;
    assign o_sample_valid = r_out_gen;

    assign mul_p = 58'(mul_a) * 58'(mul_b);

    wto_ram #(
        .WIDTH (24),
        .DEPTH (MEM_DEPTH)
    ) u_smp_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Sequencer and datapath next values
    always_comb begin
        logic [2:0]    nfr;
        logic [16:0]   pos_c;
        logic [19:0]   fpos;
        logic [2:0]    fa;
        logic [BW:0]   band_nxt;
        logic [15:0]   lim_h;
        logic          fits;
        logic [2:0]    kind;
        logic [16:0]   amt;
        logic [16:0]   a_c;
        logic [7:0]    j;
        logic [31:0]   hi32;
        logic [24:0]   lm;
        logic [24:0]   g;
        logic [33:0]   shres;
        logic [50:0]   sum;
        logic [34:0]   sum_sh;
        logic [32:0]   rem2;
        logic [32:0]   diff33;
        logic [IW:0]   idx_p1;
        logic [40:0]   mix;

        n_state      = r_state;
        n_phase      = r_phase;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_sample = r_out_sample;
        n_out_gen    = r_out_gen;
        n_nbd = r_nbd;  n_fa = r_fa;  n_fb = r_fb;  n_ff = r_ff;
        n_band = r_band; n_stg = r_stg; n_p = r_p; n_kind = r_kind;
        n_a = r_a; n_e = r_e; n_px = r_px; n_lz = r_lz; n_lo = r_lo;
        n_dif = r_dif; n_frac = r_frac; n_neg = r_neg; n_prod = r_prod;
        n_val = r_val; n_s = r_s; n_pow = r_pow; n_sh = r_sh; n_acc = r_acc;
        n_mid = r_mid; n_den = r_den; n_rem = r_rem; n_ql = r_ql; n_hi = r_hi;
        n_cnt = r_cnt; n_idx = r_idx; n_nidx = r_nidx; n_tf = r_tf;
        n_base_a = r_base_a; n_base_b = r_base_b;
        n_s0 = r_s0; n_s1 = r_s1; n_s2 = r_s2; n_s3 = r_s3;
        n_va = r_va; n_vb = r_vb; n_res = r_res;
        mul_a     = '0;
        mul_b     = '0;
        ram_we    = 1'b0;
        ram_addr  = r_base_a + AW'(r_idx);
        ram_wdata = r_lval;
        lim_we    = 1'b0;
        lim_wdata = r_lval[15:0];

        nfr      = (r_frames == 3'd0) ? 3'd1 :
                   ((32'(r_frames) > MAX_FRAMES) ? 3'(MAX_FRAMES) : r_frames);
        pos_c    = r_pos[16] ? 17'h10000 : r_pos;
        fpos     = 20'(pos_c) * 20'(nfr - 3'd1);
        fa       = fpos[18:16];
        band_nxt = (BW + 1)'(r_band) + (BW + 1)'(1);
        lim_h    = r_lim[BW'(band_nxt)];
        fits     = 1'b0;
        kind     = r_stg[0] ? r_proc_b : r_proc_a;
        amt      = r_stg[0] ? r_amt_b : r_amt_a;
        a_c      = amt[16] ? 17'h10000 : amt;
        j        = '0;
        hi32     = '0;
        lm       = '0;
        g        = '0;
        shres    = '0;
        sum      = '0;
        sum_sh   = '0;
        rem2     = '0;
        diff33   = '0;
        idx_p1   = '0;
        mix      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_DECODE;
                end
            end

            S_DECODE: begin
                case (r_cmd)
                    CMD_LOAD_SMP: begin
                        ram_addr = AW'((32'(r_fsel) * MAX_BANDS + 32'(r_bsel)) * TABLE_LENGTH
                                       + 32'(r_sidx));
                        ram_we   = (32'(r_fsel) < MAX_FRAMES) && (32'(r_bsel) < MAX_BANDS)
                                   && (32'(r_sidx) < TABLE_LENGTH);
                        n_state  = S_DONE;
                    end
                    CMD_LOAD_LIM: begin
                        lim_we = (32'(r_bsel) < MAX_BANDS);
                        if (r_lval[23]) begin
                            lim_wdata = 16'd0;
                        end else if (|r_lval[22:16]) begin
                            lim_wdata = 16'hFFFF;
                        end else begin
                            lim_wdata = r_lval[15:0];
                        end
                        n_state = S_DONE;
                    end
                    CMD_SET_PHS: begin
                        n_phase = r_sphase;
                        n_state = S_DONE;
                    end
                    default: begin
                        // Set up the band search, frame pair and phase
                        n_nbd   = (r_bands == 5'd0) ? 5'd1 :
                                  ((32'(r_bands) > MAX_BANDS) ? 5'(MAX_BANDS) : r_bands);
                        n_fa    = fa;
                        n_fb    = (fa + 3'd1 < nfr) ? fa + 3'd1 : nfr - 3'd1;
                        n_ff    = fpos[15:0];
                        n_band  = '0;
                        n_stg   = 2'd0;
                        n_p     = r_phase;
                        n_state = S_BAND;
                    end
                endcase
            end

            // Advance the band while the next limit fits under 0.45
            S_BAND: begin
                mul_a = 33'(r_ratio);
                mul_b = 25'(lim_h);
                fits  = (r_ratio == 32'd0) ? (lim_h <= 16'd1) : (mul_p[47:0] <= BAND_LIMIT);
                if ((6'(band_nxt) >= 6'(r_nbd)) || !fits) begin
                    n_state = S_STG;
                end else begin
                    n_band = BW'(band_nxt);
                end
            end

            // Start a shaping stage, or move on to the table read
            S_STG: begin
                if (r_stg == 2'd2) begin
                    n_base_a = AW'((32'(r_fa) * MAX_BANDS + 32'(r_band)) * TABLE_LENGTH);
                    n_base_b = AW'((32'(r_fb) * MAX_BANDS + 32'(r_band)) * TABLE_LENGTH);
                    n_state  = S_TAB;
                end else begin
                    n_kind = kind;
                    n_a    = a_c;
                    n_e    = 19'h10000 + {a_c, 2'b00};
                    n_lz   = '0;
                    if (a_c == 17'd0) begin
                        n_stg = r_stg + 2'd1;
                    end else begin
                        case (kind)
                            PROC_BEND_P: begin
                                n_px    = {1'b0, r_p};
                                n_state = S_PNORM;
                            end
                            PROC_BEND_M: begin
                                n_px    = ONE_PHASE - {1'b0, r_p};
                                n_state = S_PNORM;
                            end
                            PROC_BEND_B: begin
                                n_px    = r_p[31] ? 33'((ONE_PHASE - {1'b0, r_p}) << 1)
                                                  : {r_p, 1'b0};
                                n_state = S_PNORM;
                            end
                            PROC_SYNC: begin
                                n_state = S_SYNC;
                            end
                            PROC_MIRROR: begin
                                n_sh    = r_p[31] ? 33'((ONE_PHASE - {1'b0, r_p}) << 1)
                                                  : {r_p, 1'b0};
                                n_state = S_BLEND1;
                            end
                            PROC_ASYM: begin
                                n_state = S_AMID;
                            end
                            default: begin
                                n_stg = r_stg + 2'd1;
                            end
                        endcase
                    end
                end
            end

            // Power unit: normalize one bit per cycle
            S_PNORM: begin
                if (r_px == 33'd0) begin
                    n_pow   = '0;
                    n_state = S_POST;
                end else if (r_px[32]) begin
                    n_pow   = ONE_PHASE;
                    n_state = S_POST;
                end else if (r_px[31]) begin
                    n_state = S_PLOGA;
                end else begin
                    n_px = r_px << 1;
                    n_lz = r_lz + 5'd1;
                end
            end

            // Look up log2 of the mantissa
            S_PLOGA: begin
                j      = r_px[30:23];
                hi32   = (j == 8'hFF) ? 32'h0100_0000 : 32'(LOG_ROM[j + 8'd1]);
                n_lo   = 31'(LOG_ROM[j]);
                n_dif  = 25'(hi32 - 32'(LOG_ROM[j]));
                n_frac = r_px[22:0];
                n_state = S_PLOGB;
            end

            // Interpolate log2 and form the negated logarithm
            S_PLOGB: begin
                mul_a   = 33'(r_dif);
                mul_b   = 25'(r_frac);
                lm      = 25'(r_lo) + mul_p[47:23];
                n_neg   = ((30'(r_lz) + 30'd1) << 24) - 30'(lm);
                n_state = S_PEXP;
            end

            // Scale by the exponent
            S_PEXP: begin
                mul_a   = 33'(r_neg);
                mul_b   = 25'(r_e);
                n_prod  = mul_p[48:16];
                n_state = S_PEXPA;
            end

            // Split into shift and fraction, look up exp2
            S_PEXPA: begin
                if (r_prod[23:0] == 24'd0) begin
                    n_val   = 32'h4000_0000;
                    n_s     = 10'(r_prod[32:24]);
                    n_state = S_PSHIFT;
                end else begin
                    g       = 25'h100_0000 - 25'(r_prod[23:0]);
                    j       = g[23:16];
                    hi32    = (j == 8'hFF) ? 32'h8000_0000 : 32'(EXP_ROM[j + 8'd1]);
                    n_lo    = EXP_ROM[j];
                    n_dif   = 25'(hi32 - 32'(EXP_ROM[j]));
                    n_frac  = 23'(g[15:0]);
                    n_s     = 10'(r_prod[32:24]) + 10'd1;
                    n_state = S_PEXPB;
                end
            end

            // Interpolate exp2
            S_PEXPB: begin
                mul_a   = 33'(r_dif);
                mul_b   = 25'(r_frac);
                n_val   = 32'(r_lo) + 32'(mul_p[40:16]);
                n_state = S_PSHIFT;
            end

            // Apply the integer shift and saturate
            S_PSHIFT: begin
                shres = {r_val, 2'b00} >> r_s[5:0];
                if (r_s >= 10'd40) begin
                    n_pow = '0;
                end else if (|shres[33:32]) begin
                    n_pow = 33'h0_FFFF_FFFF;
                end else begin
                    n_pow = 33'(shres[31:0]);
                end
                n_state = S_POST;
            end

            // Fold the power result into the shaped phase
            S_POST: begin
                case (r_kind)
                    PROC_BEND_M: n_sh = ONE_PHASE - r_pow;
                    PROC_BEND_B: n_sh = r_p[31] ? ONE_PHASE - (r_pow >> 1) : (r_pow >> 1);
                    default:     n_sh = r_pow;
                endcase
                n_state = S_BLEND1;
            end

            S_BLEND1: begin
                mul_a   = 33'(r_p);
                mul_b   = 25'(18'h10000 - 18'(r_a));
                n_acc   = mul_p[49:0];
                n_state = S_BLEND2;
            end

            // Add the shaped part and saturate at the top of the phase
            S_BLEND2: begin
                mul_a  = r_sh;
                mul_b  = 25'(r_a);
                sum    = 51'(r_acc) + 51'(mul_p[49:0]);
                sum_sh = sum[50:16];
                n_p    = (|sum_sh[34:32]) ? 32'hFFFF_FFFF : sum_sh[31:0];
                n_stg  = r_stg + 2'd1;
                n_state = S_STG;
            end

            S_SYNC: begin
                mul_a   = 33'(r_p);
                mul_b   = 25'(20'h10000 + 20'(r_a) * 20'd7);
                n_p     = mul_p[47:16];
                n_stg   = r_stg + 2'd1;
                n_state = S_STG;
            end

            S_AMID: begin
                mul_a   = 33'(ASYM_SPAN);
                mul_b   = 25'(r_a);
                n_mid   = 32'h8000_0000 - mul_p[47:16];
                n_state = S_ASET;
            end

            // Load the divider for the side of the midpoint
            S_ASET: begin
                n_cnt = '0;
                if (r_p < r_mid) begin
                    n_rem = {1'b0, r_p[31:1]};
                    n_ql  = {r_p[0], 31'd0};
                    n_den = r_mid;
                    n_hi  = 1'b0;
                end else begin
                    diff33 = {1'b0, r_p} - {1'b0, r_mid};
                    n_rem  = {1'b0, diff33[31:1]};
                    n_ql   = {diff33[0], 31'd0};
                    n_den  = 32'(ONE_PHASE - {1'b0, r_mid});
                    n_hi   = 1'b1;
                end
                n_state = S_DIV;
            end

            // Restoring divide, one quotient bit per cycle
            S_DIV: begin
                rem2 = {r_rem, r_ql[31]};
                if (rem2 >= {1'b0, r_den}) begin
                    n_rem = 32'(rem2 - {1'b0, r_den});
                    n_ql  = {r_ql[30:0], 1'b1};
                end else begin
                    n_rem = rem2[31:0];
                    n_ql  = {r_ql[30:0], 1'b0};
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_p     = r_hi ? 32'h8000_0000 + n_ql : n_ql;
                    n_stg   = r_stg + 2'd1;
                    n_state = S_STG;
                end
            end

            // Table position, neighbor index and fraction
            S_TAB: begin
                mul_a   = 33'(r_p);
                mul_b   = 25'(TABLE_LENGTH);
                n_idx   = mul_p[32 +: IW];
                idx_p1  = (IW + 1)'(mul_p[32 +: IW]) + (IW + 1)'(1);
                n_nidx  = (32'(idx_p1) >= TABLE_LENGTH) ? '0 : IW'(idx_p1);
                n_tf    = mul_p[31:16];
                n_state = S_RD0;
            end

            // Read four samples; read data returns in the cycle after the address
            S_RD0: begin
                ram_addr = r_base_a + AW'(r_idx);
                n_state  = S_RD1;
            end
            S_RD1: begin
                ram_addr = r_base_a + AW'(r_nidx);
                n_s0     = {~ram_rdata[23], ram_rdata[22:0]};
                n_state  = S_RD2;
            end
            S_RD2: begin
                ram_addr = r_base_b + AW'(r_idx);
                n_s1     = {~ram_rdata[23], ram_rdata[22:0]};
                n_state  = S_RD3;
            end
            S_RD3: begin
                ram_addr = r_base_b + AW'(r_nidx);
                n_s2     = {~ram_rdata[23], ram_rdata[22:0]};
                n_state  = S_RD4;
            end
            S_RD4: begin
                n_s3    = {~ram_rdata[23], ram_rdata[22:0]};
                n_state = S_MIX0;
            end

            // Interpolate along the table, then between frames
            S_MIX0: begin
                mul_a   = 33'(r_s0);
                mul_b   = 25'(17'h10000 - 17'(r_tf));
                n_acc   = 50'(mul_p[40:0]);
                n_state = S_MIX1;
            end
            S_MIX1: begin
                mul_a   = 33'(r_s1);
                mul_b   = 25'(r_tf);
                mix     = 41'(r_acc) + mul_p[40:0];
                n_va    = mix[39:16];
                n_state = S_MIX2;
            end
            S_MIX2: begin
                mul_a   = 33'(r_s2);
                mul_b   = 25'(17'h10000 - 17'(r_tf));
                n_acc   = 50'(mul_p[40:0]);
                n_state = S_MIX3;
            end
            S_MIX3: begin
                mul_a   = 33'(r_s3);
                mul_b   = 25'(r_tf);
                mix     = 41'(r_acc) + mul_p[40:0];
                n_vb    = mix[39:16];
                n_state = S_MIX4;
            end
            S_MIX4: begin
                mul_a   = 33'(r_va);
                mul_b   = 25'(17'h10000 - 17'(r_ff));
                n_acc   = 50'(mul_p[40:0]);
                n_state = S_MIX5;
            end
            S_MIX5: begin
                mul_a   = 33'(r_vb);
                mul_b   = 25'(r_ff);
                mix     = 41'(r_acc) + mul_p[40:0];
                n_res   = mix[39:16];
                n_state = S_DONE;
            end

            // Hand the beat to the output register; a generate beat also advances the phase
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    if (r_cmd == CMD_GENERATE) begin
                        n_out_gen    = 1'b1;
                        n_out_sample = r_ratio[31] ? 24'd0 : {~r_res[23], r_res[22:0]};
                        n_phase      = r_phase + ((r_ratio > INC_LIMIT) ? INC_LIMIT : r_ratio);
                    end else begin
                        n_out_gen    = 1'b0;
                        n_out_sample = 24'd0;
                    end
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
            r_out_gen   <= 1'b0;
            r_frames    <= 3'd1;
            r_bands     <= 5'd1;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            r_out_gen   <= n_out_gen;
            if (cfg_wr) begin
                if (paddr[2]) begin
                    r_bands <= pwdata[4:0];
                end else begin
                    r_frames <= pwdata[2:0];
                end
            end
        end
    end

    // Capture the input beat
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd    <= i_command;
            r_ratio  <= i_frequency_ratio;
            r_pos    <= i_position;
            r_proc_a <= i_process_a;
            r_amt_a  <= i_amount_a;
            r_proc_b <= i_process_b;
            r_amt_b  <= i_amount_b;
            r_fsel   <= i_frame_select;
            r_bsel   <= i_band_select;
            r_sidx   <= i_sample_index;
            r_lval   <= i_load_value;
            r_sphase <= i_start_phase;
        end
        if (lim_we) begin
            r_lim[BW'(r_bsel)] <= lim_wdata;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_out_sample <= n_out_sample;
        r_nbd  <= n_nbd;  r_fa <= n_fa;  r_fb <= n_fb;  r_ff <= n_ff;
        r_band <= n_band; r_stg <= n_stg; r_p <= n_p; r_kind <= n_kind;
        r_a    <= n_a;    r_e <= n_e;    r_px <= n_px; r_lz <= n_lz;
        r_lo   <= n_lo;   r_dif <= n_dif; r_frac <= n_frac; r_neg <= n_neg;
        r_prod <= n_prod; r_val <= n_val; r_s <= n_s; r_pow <= n_pow;
        r_sh   <= n_sh;   r_acc <= n_acc; r_mid <= n_mid; r_den <= n_den;
        r_rem  <= n_rem;  r_ql <= n_ql;  r_hi <= n_hi;  r_cnt <= n_cnt;
        r_idx  <= n_idx;  r_nidx <= n_nidx; r_tf <= n_tf;
        r_base_a <= n_base_a; r_base_b <= n_base_b;
        r_s0 <= n_s0; r_s1 <= n_s1; r_s2 <= n_s2; r_s3 <= n_s3;
        r_va <= n_va; r_vb <= n_vb; r_res <= n_res;
        r_nbd_unused_guard <= n_fb ^ n_fa;
    end

endmodule

[tb/tb_wavetable_oscillator_unit.sv]
// ----------------------------------------------------------------------------
// tb_wavetable_oscillator_unit
// Self-checking testbench of the wavetable oscillator. It fills the band
// tables and harmonic limits, then runs directed and random command beats
// under several frame and band settings. A built-in predictor computes each
// expected output beat, and the monitor compares the beats in order.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_wavetable_oscillator_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import wto_pkg::*;

    localparam int          N_FRAMES   = 4;
    localparam int          N_BANDS    = 16;
    localparam int          TBL_LEN    = 2048;
    localparam logic [63:0] PH_ONE     = 64'h1_0000_0000;
    localparam logic [63:0] STEP_CEIL  = 64'd2143188680;
    localparam logic [63:0] ASYM_WIDTH = 64'd1632087572;
    localparam int          REG_FRAMES = 0;
    localparam int          REG_BANDS  = 1;
    // Smallest nonzero ratio for which a full-scale harmonic limit fails
    localparam logic [31:0] LOW_RATIO  = 32'd29492;

    typedef struct {
        t_cmd               cmd;
        logic [31:0]        ratio;
        logic [16:0]        pos;
        logic [2:0]         proc_a;
        logic [16:0]        amt_a;
        logic [2:0]         proc_b;
        logic [16:0]        amt_b;
        logic [1:0]         frm;
        logic [3:0]         band;
        logic [10:0]        idx;
        logic signed [23:0] value;
        logic [31:0]        start;
    } t_beat;

    typedef struct {
        logic signed [23:0] sample;
        logic               sample_valid;
    } t_sample_beat;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [23:0] o_sample_out;
    logic               o_sample_valid;

    t_beat drv_beat;

    t_beat        cmd_q[$];
    t_sample_beat sample_q[$];

    // Predictor state
    logic [63:0]        log_tbl [256];
    logic [63:0]        exp_tbl [256];
    logic [31:0]        osc_phase;
    logic signed [23:0] wave_mem [N_FRAMES * N_BANDS * TBL_LEN];
    logic [15:0]        limit_mem [N_BANDS];
    logic [2:0]         cfg_frames;
    logic [4:0]         cfg_bands;

    int errors;
    int results_seen;
    int send_gap;
    int send_burst;
    int stall_left;
    int hold_left;
    bit hold_done;

    wavetable_oscillator_unit u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_command         (drv_beat.cmd),
        .i_frequency_ratio (drv_beat.ratio),
        .i_position        (drv_beat.pos),
        .i_process_a       (drv_beat.proc_a),
        .i_amount_a        (drv_beat.amt_a),
        .i_process_b       (drv_beat.proc_b),
        .i_amount_b        (drv_beat.amt_b),
        .i_frame_select    (drv_beat.frm),
        .i_band_select     (drv_beat.band),
        .i_sample_index    (drv_beat.idx),
        .i_load_value      (drv_beat.value),
        .i_start_phase     (drv_beat.start),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_sample_out      (o_sample_out),
        .o_sample_valid    (o_sample_valid)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [63:0] int_root(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] probe;
        v     = v_in;
        res   = '0;
        probe = 64'd1 << 62;
        while (probe > v) probe = probe >> 2;
        while (probe != 0) begin
            if (v >= res + probe) begin
                v   = v - (res + probe);
                res = (res >> 1) + probe;
            end else begin
                res = res >> 1;
            end
            probe = probe >> 2;
        end
        return res;
    endfunction

    task automatic build_curves();
        logic [63:0] roots [1:8];
        logic [63:0] r;
        logic [63:0] v;
        logic [63:0] m;
        logic [63:0] y;
        r = 64'd2 << 30;
        for (int k = 1; k <= 8; k++) begin
            r        = int_root(r << 30);
            roots[k] = r;
        end
        for (int i = 0; i < 256; i++) begin
            v = 64'd1 << 30;
            for (int k = 1; k <= 8; k++) begin
                if (((i >> (8 - k)) & 1) != 0) v = (v * roots[k]) >> 30;
            end
            exp_tbl[i] = v;
            m = 64'(256 + i) << 22;
            y = '0;
            for (int b = 23; b >= 0; b--) begin
                m = (m * m) >> 30;
                if (m >= (64'd2 << 30)) begin
                    m    = m >> 1;
                    y[b] = 1'b1;
                end
            end
            log_tbl[i] = y;
        end
    endtask

    // x^e, x on the 0.32 scale, e Q.16 at least one
    function automatic logic [63:0] raise_phase(input logic [63:0] x, input logic [63:0] e);
        logic [63:0] xs, fr, lo, hi, lm, neg, prod, ip, f, val, s, g, res;
        int          lz;
        int          j;
        if (x == 0) return 64'd0;
        xs = x;
        lz = 0;
        while (xs[31] == 1'b0) begin
            xs = xs << 1;
            lz++;
        end
        fr   = xs & 64'h7FFF_FFFF;
        j    = int'(fr >> 23);
        lo   = log_tbl[j];
        hi   = (j < 255) ? log_tbl[j + 1] : (64'd1 << 24);
        lm   = lo + (((hi - lo) * (fr & 64'h7F_FFFF)) >> 23);
        neg  = ((64'(lz) + 1) << 24) - lm;
        prod = (neg * e) >> 16;
        ip   = prod >> 24;
        f    = prod & 64'hFF_FFFF;
        if (f == 0) begin
            val = 64'd1 << 30;
            s   = ip;
        end else begin
            g   = (64'd1 << 24) - f;
            j   = int'(g >> 16);
            lo  = exp_tbl[j];
            hi  = (j < 255) ? exp_tbl[j + 1] : (64'd2 << 30);
            val = lo + (((hi - lo) * (g & 64'hFFFF)) >> 16);
            s   = ip + 1;
        end
        if (s >= 40) return 64'd0;
        res = (val << 2) >> s;
        return (res > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : res;
    endfunction

    function automatic logic [31:0] clip_phase(input logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic logic [31:0] mix_phase(input logic [63:0] p, input logic [63:0] s,
                                              input logic [63:0] a);
        return clip_phase((p * (64'd65536 - a) + s * a) >> 16);
    endfunction

    function automatic logic [63:0] raise_or_one(input logic [63:0] q, input logic [63:0] e);
        return (q >= PH_ONE) ? PH_ONE : raise_phase(q, e);
    endfunction

    function automatic logic [31:0] shape_phase(input logic [31:0] ph, input logic [2:0] kind,
                                                input logic [16:0] amt);
        logic [63:0] p, a, e, sh, q, mid;
        p = 64'(ph);
        a = (amt > 17'd65536) ? 64'd65536 : 64'(amt);
        e = 64'd65536 + 4 * a;
        if (a == 0) return ph;
        case (kind)
            PROC_BEND_P: begin
                return mix_phase(p, raise_phase(p, e), a);
            end
            PROC_BEND_M: begin
                sh = PH_ONE - raise_or_one(PH_ONE - p, e);
                return mix_phase(p, sh, a);
            end
            PROC_BEND_B: begin
                if (p < (64'd1 << 31)) begin
                    sh = raise_phase(p << 1, e) >> 1;
                end else begin
                    q  = (PH_ONE - p) << 1;
                    sh = PH_ONE - (raise_or_one(q, e) >> 1);
                end
                return mix_phase(p, sh, a);
            end
            PROC_SYNC: begin
                sh = (p * (64'd65536 + 7 * a)) >> 16;
                return sh[31:0];
            end
            PROC_MIRROR: begin
                sh = (p < (64'd1 << 31)) ? (p << 1) : ((PH_ONE - p) << 1);
                return mix_phase(p, sh, a);
            end
            PROC_ASYM: begin
                mid = (64'd1 << 31) - ((ASYM_WIDTH * a) >> 16);
                if (p < mid) begin
                    sh = (p << 31) / mid;
                    return sh[31:0];
                end
                return clip_phase((64'd1 << 31) + ((p - mid) << 31) / (PH_ONE - mid));
            end
            default: return ph;
        endcase
    endfunction

    function automatic longint lerp_q21(input longint s0, input longint s1, input longint f);
        longint u0;
        longint u1;
        u0 = s0 + 8388608;
        u1 = s1 + 8388608;
        return ((u0 * (65536 - f) + u1 * f) >>> 16) - 8388608;
    endfunction

    function automatic longint table_read(input int fr, input int band, input int idx,
                                          input int nidx, input longint f);
        int base;
        base = (fr * N_BANDS + band) * TBL_LEN;
        return lerp_q21(wave_mem[base + idx], wave_mem[base + nidx], f);
    endfunction

    // Advance the oscillator by one beat and queue the output it gives
    task automatic osc_step(input t_beat b);
        t_sample_beat r;
        logic [63:0]  ratio, h, pos, fpos, tp, tf, ff;
        int           nfr, nbd, band, fa, fb, idx, nidx;
        longint       va, vb, res;
        logic [31:0]  rp;
        bit           fits;
        r.sample       = '0;
        r.sample_valid = 1'b0;
        case (b.cmd)
            CMD_LOAD_SMP: begin
                wave_mem[(int'(b.frm) * N_BANDS + int'(b.band)) * TBL_LEN + int'(b.idx)] = b.value;
            end
            CMD_LOAD_LIM: begin
                if (b.value < 0) limit_mem[b.band] = 16'd0;
                else if (b.value > 24'sd65535) limit_mem[b.band] = 16'hFFFF;
                else limit_mem[b.band] = b.value[15:0];
            end
            CMD_SET_PHS: begin
                osc_phase = b.start;
            end
            default: begin
                ratio = 64'(b.ratio);
                nfr   = (cfg_frames == 0) ? 1 : ((cfg_frames > N_FRAMES) ? N_FRAMES : cfg_frames);
                nbd   = (cfg_bands == 0) ? 1 : ((cfg_bands > N_BANDS) ? N_BANDS : cfg_bands);
                // Climb bands while the next one stays under the harmonic ceiling
                band = 0;
                while (band + 1 < nbd) begin
                    h    = 64'(limit_mem[band + 1]);
                    fits = (ratio == 0) ? (h <= 1) : (64'd20 * h * ratio <= 64'd9 * PH_ONE);
                    if (!fits) break;
                    band++;
                end
                pos  = (b.pos > 17'd65536) ? 64'd65536 : 64'(b.pos);
                fpos = pos * 64'(nfr - 1);
                fa   = int'(fpos >> 16);
                ff   = fpos & 64'hFFFF;
                fb   = (fa + 1 < nfr) ? fa + 1 : nfr - 1;
                rp   = shape_phase(osc_phase, b.proc_a, b.amt_a);
                rp   = shape_phase(rp, b.proc_b, b.amt_b);
                tp   = 64'(rp) * TBL_LEN;
                idx  = int'(tp >> 32);
                nidx = (idx + 1 >= TBL_LEN) ? 0 : idx + 1;
                tf   = (tp >> 16) & 64'hFFFF;
                va   = table_read(fa, band, idx, nidx, longint'(tf));
                vb   = table_read(fb, band, idx, nidx, longint'(tf));
                res  = lerp_q21(va, vb, longint'(ff));
                if (res > 8388607) res = 8388607;
                if (res < -8388608) res = -8388608;
                osc_phase = osc_phase + ((ratio > STEP_CEIL) ? STEP_CEIL[31:0] : b.ratio);
                if (ratio >= (64'd1 << 31)) res = 0;
                r.sample       = res[23:0];
                r.sample_valid = 1'b1;
            end
        endcase
        sample_q.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 90);
    endfunction

    function automatic t_beat noise_beat(input t_cmd cmd);
        t_beat b;
        b.cmd    = cmd;
        b.ratio  = $urandom;
        b.pos    = $urandom_range(0, 131071);
        b.proc_a = $urandom_range(0, 7);
        b.amt_a  = $urandom_range(0, 131071);
        b.proc_b = $urandom_range(0, 7);
        b.amt_b  = $urandom_range(0, 131071);
        b.frm    = $urandom_range(0, 3);
        b.band   = $urandom_range(0, 15);
        b.idx    = $urandom_range(0, 2047);
        b.value  = $urandom;
        b.start  = $urandom;
        return b;
    endfunction

    function automatic logic [16:0] rand_amount();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 17'd0;
        if (r == 1) return 17'd65536;
        if (r == 2) return $urandom_range(65537, 131071);
        return $urandom_range(1, 65535);
    endfunction

    // Generate beat; with more than two bands in use, keep away from tiny
    // nonzero ratios so the band search never climbs past band one
    function automatic t_beat gen_beat(input bit many_bands);
        t_beat b;
        int    r;
        b = noise_beat(CMD_GENERATE);
        r = $urandom_range(0, 9);
        if (r == 0) b.ratio = 32'd0;
        else if (r < 5) b.ratio = $urandom_range(0, 32'h0400_0000);
        else if (r < 8) b.ratio = $urandom_range(0, 32'h7FFF_FFFF);
        if (many_bands && b.ratio != 0 && b.ratio < LOW_RATIO) b.ratio = b.ratio + LOW_RATIO;
        r = $urandom_range(0, 9);
        if (r == 0) b.pos = 17'd65536;
        else if (r == 1) b.pos = 17'd0;
        else if (r < 8) b.pos = $urandom_range(0, 65536);
        b.amt_a = rand_amount();
        b.amt_b = rand_amount();
        return b;
    endfunction

    function automatic t_beat rand_beat(input bit many_bands);
        t_beat b;
        int    r;
        r = $urandom_range(0, 99);
        if (r < 70) return gen_beat(many_bands);
        if (r < 80) return noise_beat(CMD_LOAD_SMP);
        if (r < 88) begin
            b = noise_beat(CMD_LOAD_LIM);
            // Band two must stay at full scale
            if (b.band == 4'd2) b.value = $urandom_range(65535, 8388607);
            return b;
        end
        b = noise_beat(CMD_SET_PHS);
        return b;
    endfunction

    function automatic t_beat directed_gen(input logic [31:0] ratio, input logic [16:0] pos,
                                           input logic [2:0] pa, input logic [16:0] aa,
                                           input logic [2:0] pb, input logic [16:0] ab);
        t_beat b;
        b        = noise_beat(CMD_GENERATE);
        b.ratio  = ratio;
        b.pos    = pos;
        b.proc_a = pa;
        b.amt_a  = aa;
        b.proc_b = pb;
        b.amt_b  = ab;
        return b;
    endfunction

    task automatic cfg_write(input int reg_idx, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(reg_idx * 4);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_FRAMES) cfg_frames = data[2:0];
        else cfg_bands = data[4:0];
    endtask

    task automatic set_shape(input logic [31:0] frames, input logic [31:0] bands);
        cfg_write(REG_FRAMES, frames);
        cfg_write(REG_BANDS, bands);
    endtask

    // Let every queued beat and expected output drain, then let the block settle
    task automatic drain();
        @(posedge i_clk);
        while (cmd_q.size() != 0 || i_in_valid || sample_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Clock, reset, limit
    // ------------------------------------------------------------------

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender: present queued beats with random gaps and gap-free bursts
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
            send_burst <= 0;
        end else if (i_in_valid && !o_in_stall) begin
            osc_step(drv_beat);
            if (send_burst > 0) begin
                send_burst <= send_burst - 1;
                if (cmd_q.size() != 0) drv_beat <= cmd_q.pop_front();
                else i_in_valid <= 1'b0;
            end else if ($urandom_range(0, 99) < 3) begin
                send_burst <= $urandom_range(10, 40);
                i_in_valid <= 1'b0;
            end else begin
                send_gap = pick_gap();
                if (send_gap == 0 && cmd_q.size() != 0) drv_beat <= cmd_q.pop_front();
                else i_in_valid <= 1'b0;
            end
        end else if (!i_in_valid) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (cmd_q.size() != 0) begin
                drv_beat   <= cmd_q.pop_front();
                i_in_valid <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off once traffic is busy
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
            hold_left   <= 0;
            hold_done   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (!hold_done && results_seen >= 16500) begin
            hold_done   <= 1'b1;
            hold_left   <= 600;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < 25) begin
            stall_left  <= pick_gap();
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each output beat with the oldest expectation
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_sample_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen <= results_seen + 1;
            if (sample_q.size() == 0) begin
                $error("output beat with nothing expected: sample_out %0d", o_sample_out);
                errors++;
            end else begin
                want = sample_q.pop_front();
                if (o_sample_out !== want.sample) begin
                    $error("sample_out: expected %0d, got %0d", want.sample, o_sample_out);
                    errors++;
                end
                if (o_sample_valid !== want.sample_valid) begin
                    $error("sample_valid: expected %0b, got %0b",
                           want.sample_valid, o_sample_valid);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial begin
        t_beat       b;
        logic [31:0] shapes [6][2];
        errors       = 0;
        results_seen = 0;
        osc_phase    = '0;
        cfg_frames   = 3'd1;
        cfg_bands    = 5'd1;
        foreach (limit_mem[k]) limit_mem[k] = '0;
        foreach (wave_mem[k]) wave_mem[k] = '0;
        build_curves();
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        drv_beat = noise_beat(CMD_GENERATE);
        i_rst_n  = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        set_shape(32'd4, 32'd2);

        // Load harmonic limits; band two at full scale caps the band search
        for (int k = 0; k < N_BANDS; k++) begin
            b       = noise_beat(CMD_LOAD_LIM);
            b.band  = k;
            b.value = (k == 2) ? 24'sd65535 : 24'($urandom_range(0, 65535));
            cmd_q.push_back(b);
        end
        // Fill every frame of bands zero and one
        for (int f = 0; f < N_FRAMES; f++) begin
            for (int bd = 0; bd < 2; bd++) begin
                for (int i = 0; i < TBL_LEN; i++) begin
                    b      = noise_beat(CMD_LOAD_SMP);
                    b.frm  = f;
                    b.band = bd;
                    b.idx  = i;
                    cmd_q.push_back(b);
                end
            end
        end
        drain();

        // Directed: field extremes, every shaping kind, special cases
        b = noise_beat(CMD_SET_PHS);
        b.start = 32'hFFFF_FFFF;
        cmd_q.push_back(b);
        cmd_q.push_back(directed_gen(32'd0, 17'd0, PROC_OFF, 17'd65536, PROC_OFF, 17'd0));
        cmd_q.push_back(directed_gen(32'd1, 17'd65536, PROC_BEND_P, 17'd65536,
                                     PROC_BEND_M, 17'd65536));
        for (int k = 0; k < 8; k++) begin
            cmd_q.push_back(directed_gen($urandom_range(0, 32'h0100_0000), $urandom_range(0, 65536),
                                         3'(k), 17'd65536, 3'(7 - k), $urandom_range(1, 65535)));
        end
        cmd_q.push_back(directed_gen(STEP_CEIL[31:0], 17'd131071, PROC_BEND_B, 17'd131071,
                                     PROC_ASYM, 17'd131071));
        cmd_q.push_back(directed_gen(STEP_CEIL[31:0] + 1, 17'd32768, PROC_SYNC, 17'd1,
                                     PROC_MIRROR, 17'd0));
        cmd_q.push_back(directed_gen(32'h8000_0000, 17'd1, PROC_ASYM, 17'd65536,
                                     PROC_OFF, 17'd0));
        cmd_q.push_back(directed_gen(32'hFFFF_FFFF, 17'd65535, 3'd7, 17'd131071,
                                     PROC_BEND_P, 17'd1));
        b = noise_beat(CMD_SET_PHS);
        b.start = 32'd0;
        cmd_q.push_back(b);
        cmd_q.push_back(directed_gen(32'd0, 17'd0, PROC_BEND_B, 17'd65536, PROC_ASYM, 17'd65536));
        // Harmonic limit saturation both ways on band one, low first, then high
        b = noise_beat(CMD_LOAD_LIM);
        b.band  = 4'd1;
        b.value = -24'sd8388608;
        cmd_q.push_back(b);
        cmd_q.push_back(directed_gen(32'd1, 17'd40000, PROC_OFF, 17'd0, PROC_OFF, 17'd0));
        b.value = 24'sd8388607;
        cmd_q.push_back(b);
        cmd_q.push_back(directed_gen(32'd1, 17'd40000, PROC_OFF, 17'd0, PROC_OFF, 17'd0));
        cmd_q.push_back(directed_gen(32'd29491, 17'd20000, PROC_MIRROR, 17'd65536,
                                     PROC_SYNC, 17'd65536));
        cmd_q.push_back(directed_gen(32'd29492, 17'd20000, PROC_BEND_M, 17'd1,
                                     PROC_BEND_P, 17'd131071));
        drain();

        // Random phases over several frame and band settings
        shapes = '{'{32'd1, 32'd1}, '{32'd4, 32'd16}, '{32'd0, 32'd0},
                   '{32'd7, 32'd31}, '{32'd2, 32'd2}, '{32'd3, 32'd5}};
        for (int ph = 0; ph < 6; ph++) begin
            set_shape(shapes[ph][0], shapes[ph][1]);
            for (int n = 0; n < 200; n++) begin
                cmd_q.push_back(rand_beat(cfg_bands > 5'd2));
            end
            drain();
        end

        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
